// ===== hdl/sur_pkg.sv =====
// Shared constants, codes and word types for the sort-unique-reduce block.
package sur_pkg;

  // Sizes of the stores and of the fields.
  localparam int unsigned MaxParticles = 1024;
  localparam int unsigned IdxW = $clog2(MaxParticles);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned PosW = 32;
  localparam int unsigned WgtW = 32;
  localparam int unsigned SumW = 48;
  localparam int unsigned FldW = 32;
  localparam int unsigned CmdW = 3;

  // Command codes.
  localparam logic [CmdW-1:0] CmdLoad        = 3'd0;
  localparam logic [CmdW-1:0] CmdReadUnique  = 3'd1;
  localparam logic [CmdW-1:0] CmdReadMap     = 3'd2;
  localparam logic [CmdW-1:0] CmdLoadField   = 3'd3;
  localparam logic [CmdW-1:0] CmdReadField   = 3'd4;

  // Status codes.
  localparam logic [1:0] StatOk         = 2'd0;
  localparam logic [1:0] StatBadIndex   = 2'd1;
  localparam logic [1:0] StatNotReduced = 2'd2;
  localparam logic [1:0] StatOverflow   = 2'd3;

  // Input word.
  typedef struct packed {
    logic [CmdW-1:0]        command;
    logic signed [PosW-1:0] position;
    logic signed [WgtW-1:0] weight;
    logic signed [FldW-1:0] field_in;
    logic [IdxW-1:0]        index;
    logic                   last;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [PosW-1:0] unique_position;
    logic signed [SumW-1:0] weight_sum;
    logic [IdxW-1:0]        map_index;
    logic signed [FldW-1:0] field_out;
    logic [CntW-1:0]        unique_count;
    logic [1:0]             status;
  } out_word_t;

  // Operation the controller asks of the datapath in each cycle.
  typedef enum logic [3:0] {
    OpIdle,
    OpClear,
    OpAccept,
    OpSortKey,
    OpSortLatch,
    OpSortPrev,
    OpSortCmp,
    OpMrgRd,
    OpMrgW,
    OpMrgAcc,
    OpResp1,
    OpResp2
  } dp_op_e;

  // Conditions the datapath reports back to the controller.
  typedef struct packed {
    logic clear_done;
    logic key_done;
    logic j_zero;
    logic greater;
    logic mrg_last;
    logic field_gather;
  } dp_status_t;

endpackage

// ===== hdl/sort_unique_reduce_by_key.sv =====
// Top level of the sort, merge and reduce-by-key block with map and gather.
// Loads other than the last, and field loads, keep busy low: one word per cycle.
// A unique or map read holds busy high in StResp1; its read data and then its result word
// are registered before the strobe. A field read with good status also passes StResp2, as
// the map read addresses the field memory. The last load runs an insertion sort, then a
// merge. After reset busy stays high while the field memory is cleared; the receiver
// cannot stall results.
module sort_unique_reduce_by_key (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sur_pkg::in_word_t  in_i,
  output logic               result_valid_o,
  output sur_pkg::out_word_t result_o
);

  sur_pkg::dp_op_e     op;
  sur_pkg::dp_status_t dp_status;

  // Sequencer.
  sur_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (in_i.command),
    .last_i    (in_i.last),
    .status_i  (dp_status),
    .busy_o    (busy),
    .op_o      (op)
  );

  // Memories and arithmetic.
  sur_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .in_i           (in_i),
    .status_o       (dp_status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== hdl/sur_ctrl.sv =====
// Controller state machine that sequences the field clear, loads, reads, the sort and the merge.
module sur_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [sur_pkg::CmdW-1:0] command_i,
  input  logic                    last_i,
  input  sur_pkg::dp_status_t     status_i,
  output logic                    busy_o,
  output sur_pkg::dp_op_e         op_o
);

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StSortKey,
    StSortLatch,
    StSortPrev,
    StSortCmp,
    StMrgRd,
    StMrgW,
    StMrgAcc,
    StResp1,
    StResp2
  } state_e;

  state_e state_q;
  logic   accept;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  // Operation for the datapath follows the state.
  always_comb begin
    case (state_q)
      StClear:     op_o = sur_pkg::OpClear;
      StIdle:      op_o = accept ? sur_pkg::OpAccept : sur_pkg::OpIdle;
      StSortKey:   op_o = sur_pkg::OpSortKey;
      StSortLatch: op_o = sur_pkg::OpSortLatch;
      StSortPrev:  op_o = sur_pkg::OpSortPrev;
      StSortCmp:   op_o = sur_pkg::OpSortCmp;
      StMrgRd:     op_o = sur_pkg::OpMrgRd;
      StMrgW:      op_o = sur_pkg::OpMrgW;
      StMrgAcc:    op_o = sur_pkg::OpMrgAcc;
      StResp1:     op_o = sur_pkg::OpResp1;
      StResp2:     op_o = sur_pkg::OpResp2;
      default:     op_o = sur_pkg::OpIdle;
    endcase
  end

  // State register and transitions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      case (state_q)
        StClear: begin
          if (status_i.clear_done) state_q <= StIdle;
        end
        StIdle: begin
          if (accept) begin
            case (command_i)
              sur_pkg::CmdLoad: begin
                if (last_i) state_q <= StSortKey;
              end
              sur_pkg::CmdReadUnique,
              sur_pkg::CmdReadMap,
              sur_pkg::CmdReadField: state_q <= StResp1;
              default: state_q <= StIdle;
            endcase
          end
        end
        StSortKey: begin
          state_q <= status_i.key_done ? StMrgRd : StSortLatch;
        end
        StSortLatch: state_q <= StSortPrev;
        StSortPrev: begin
          state_q <= status_i.j_zero ? StSortKey : StSortCmp;
        end
        StSortCmp: begin
          state_q <= status_i.greater ? StSortPrev : StSortKey;
        end
        StMrgRd: state_q <= StMrgW;
        StMrgW:  state_q <= StMrgAcc;
        StMrgAcc: begin
          state_q <= status_i.mrg_last ? StIdle : StMrgRd;
        end
        StResp1: begin
          state_q <= status_i.field_gather ? StResp2 : StIdle;
        end
        StResp2: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== hdl/sur_dp.sv =====
// Datapath with the particle and unique-entry memories, counters and result register.
module sur_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sur_pkg::dp_op_e     op_i,
  input  sur_pkg::in_word_t   in_i,
  output sur_pkg::dp_status_t status_o,
  output logic                result_valid_o,
  output sur_pkg::out_word_t  result_o
);

  localparam int unsigned IdxW = sur_pkg::IdxW;
  localparam int unsigned CntW = sur_pkg::CntW;
  localparam int unsigned PosW = sur_pkg::PosW;
  localparam int unsigned WgtW = sur_pkg::WgtW;
  localparam int unsigned SumW = sur_pkg::SumW;
  localparam int unsigned FldW = sur_pkg::FldW;
  localparam int unsigned Depth = sur_pkg::MaxParticles;

  // Sort key: position with the particle it came from.
  typedef struct packed {
    logic signed [PosW-1:0] pos;
    logic [IdxW-1:0]        idx;
  } key_t;

  // Memories.
  key_t                   key_mem  [Depth];
  logic [WgtW-1:0]        w_mem    [Depth];
  logic [IdxW-1:0]        map_mem  [Depth];
  logic [PosW-1:0]        upos_mem [Depth];
  logic [SumW-1:0]        usum_mem [Depth];
  logic [FldW-1:0]        fld_mem  [Depth];

  // Memory ports.
  logic            key_we, w_we, map_we, uni_we, fld_we;
  logic [IdxW-1:0] key_waddr, key_raddr, w_raddr, map_waddr, uni_waddr, fld_waddr;
  key_t            key_wdata, key_rd_q;
  logic [WgtW-1:0] w_rd_q;
  logic [IdxW-1:0] map_wdata, map_rd_q;
  logic [PosW-1:0] upos_wdata, upos_rd_q;
  logic [SumW-1:0] usum_wdata, usum_rd_q;
  logic [FldW-1:0] fld_wdata, fld_rd_q;

  // Control and working registers.
  logic [CntW-1:0]        count_q, count_d, distinct_q, distinct_d, i_q, i_d, count_eff;
  logic                   reduced_q, reduced_d, overflow_q, overflow_d, ovf_eff;
  logic [IdxW-1:0]        clr_q, clr_d, j_q, j_d, u_q, u_d, u_new;
  key_t                   key_q, key_d, cur_q, cur_d;
  logic signed [PosW-1:0] upos_q, upos_d;
  logic [SumW-1:0]        sum_q, sum_d, sum_new, w_ext;
  logic [sur_pkg::CmdW-1:0] cmd_q, cmd_d;
  logic [1:0]             stat_q, stat_d, stat_new;
  logic                   valid_q, valid_d, greater, new_group, data_ok;
  sur_pkg::out_word_t     out_q, out_d;

  assign count_eff = reduced_q ? '0 : count_q;
  assign ovf_eff   = reduced_q ? 1'b0 : overflow_q;
  assign greater   = $signed(key_rd_q.pos) > $signed(key_q.pos);
  assign w_ext     = {{(SumW - WgtW){w_rd_q[WgtW-1]}}, w_rd_q};
  assign new_group = (i_q == '0) || ($signed(cur_q.pos) > upos_q);
  assign u_new     = (i_q == '0) ? '0 : (new_group ? u_q + 1'b1 : u_q);
  assign sum_new   = new_group ? w_ext : sum_q + w_ext;
  assign data_ok   = (stat_q == sur_pkg::StatOk) || (stat_q == sur_pkg::StatOverflow);

  // Status of a read command, checked against the flags as they stand.
  always_comb begin
    if (!reduced_q) begin
      stat_new = sur_pkg::StatNotReduced;
    end else if (in_i.command == sur_pkg::CmdReadUnique) begin
      stat_new = ({1'b0, in_i.index} < distinct_q) ? sur_pkg::StatOk : sur_pkg::StatBadIndex;
    end else begin
      stat_new = ({1'b0, in_i.index} < count_q) ? sur_pkg::StatOk : sur_pkg::StatBadIndex;
    end
    if (stat_new == sur_pkg::StatOk && overflow_q) stat_new = sur_pkg::StatOverflow;
  end

  // Per-operation next values and memory accesses.
  always_comb begin
    count_d    = count_q;
    distinct_d = distinct_q;
    reduced_d  = reduced_q;
    overflow_d = overflow_q;
    clr_d      = clr_q;
    i_d        = i_q;
    j_d        = j_q;
    u_d        = u_q;
    key_d      = key_q;
    cur_d      = cur_q;
    upos_d     = upos_q;
    sum_d      = sum_q;
    cmd_d      = cmd_q;
    stat_d     = stat_q;
    valid_d    = 1'b0;
    out_d      = out_q;
    key_we     = 1'b0;
    key_waddr  = '0;
    key_wdata  = key_q;
    key_raddr  = '0;
    w_we       = 1'b0;
    w_raddr    = cur_d.idx;
    map_we     = 1'b0;
    map_waddr  = cur_q.idx;
    map_wdata  = u_new;
    uni_we     = 1'b0;
    uni_waddr  = u_new;
    upos_wdata = cur_q.pos;
    usum_wdata = sum_new;
    fld_we     = 1'b0;
    fld_waddr  = in_i.index;
    fld_wdata  = in_i.field_in;

    case (op_i)
      sur_pkg::OpClear: begin
        fld_we    = 1'b1;
        fld_waddr = clr_q;
        fld_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      sur_pkg::OpAccept: begin
        case (in_i.command)
          sur_pkg::CmdLoad: begin
            reduced_d  = 1'b0;
            distinct_d = reduced_q ? '0 : distinct_q;
            overflow_d = ovf_eff;
            count_d    = count_eff;
            if (count_eff < CntW'(Depth)) begin
              key_we    = 1'b1;
              key_waddr = count_eff[IdxW-1:0];
              key_wdata = '{pos: in_i.position, idx: count_eff[IdxW-1:0]};
              w_we      = 1'b1;
              count_d   = count_eff + 1'b1;
            end else begin
              overflow_d = 1'b1;
            end
            if (in_i.last) i_d = CntW'(1);
          end
          sur_pkg::CmdLoadField: fld_we = 1'b1;
          sur_pkg::CmdReadUnique,
          sur_pkg::CmdReadMap,
          sur_pkg::CmdReadField: begin
            cmd_d  = in_i.command;
            stat_d = stat_new;
          end
          default: ;
        endcase
      end
      sur_pkg::OpSortKey: begin
        key_raddr = i_q[IdxW-1:0];
        if (i_q >= count_q) i_d = '0;
      end
      sur_pkg::OpSortLatch: begin
        key_d = key_rd_q;
        j_d   = i_q[IdxW-1:0];
      end
      sur_pkg::OpSortPrev: begin
        if (j_q == '0) begin
          key_we    = 1'b1;
          key_waddr = '0;
          i_d       = i_q + 1'b1;
        end else begin
          key_raddr = j_q - 1'b1;
        end
      end
      sur_pkg::OpSortCmp: begin
        key_we    = 1'b1;
        key_waddr = j_q;
        if (greater) begin
          key_wdata = key_rd_q;
          j_d       = j_q - 1'b1;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      sur_pkg::OpMrgRd: key_raddr = i_q[IdxW-1:0];
      sur_pkg::OpMrgW: begin
        // The weight of the particle just read is fetched for the next step.
        cur_d   = key_rd_q;
        w_raddr = key_rd_q.idx;
      end
      sur_pkg::OpMrgAcc: begin
        map_we     = 1'b1;
        uni_we     = 1'b1;
        u_d        = u_new;
        upos_d     = cur_q.pos;
        sum_d      = sum_new;
        distinct_d = {1'b0, u_new} + 1'b1;
        i_d        = i_q + 1'b1;
        if (i_q + 1'b1 == count_q) reduced_d = 1'b1;
      end
      sur_pkg::OpResp1: begin
        out_d.unique_position = (data_ok && cmd_q == sur_pkg::CmdReadUnique) ? upos_rd_q : '0;
        out_d.weight_sum      = (data_ok && cmd_q == sur_pkg::CmdReadUnique) ? usum_rd_q : '0;
        out_d.map_index       = (data_ok && cmd_q != sur_pkg::CmdReadUnique) ? map_rd_q : '0;
        out_d.field_out       = '0;
        out_d.unique_count    = distinct_q;
        out_d.status          = stat_q;
        valid_d               = !status_o.field_gather;
      end
      sur_pkg::OpResp2: begin
        // The map entry was captured in the first response step.
        out_d.unique_position = '0;
        out_d.weight_sum      = '0;
        out_d.map_index       = out_q.map_index;
        out_d.field_out       = fld_rd_q;
        out_d.unique_count    = distinct_q;
        out_d.status          = stat_q;
        valid_d               = 1'b1;
      end
      default: ;
    endcase
  end

  // Status back to the controller.
  assign status_o.clear_done   = &clr_q;
  assign status_o.key_done     = (i_q >= count_q);
  assign status_o.j_zero       = (j_q == '0);
  assign status_o.greater      = greater;
  assign status_o.mrg_last     = (i_q + 1'b1 == count_q);
  assign status_o.field_gather = data_ok && (cmd_q == sur_pkg::CmdReadField);

  // Key memory.
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rd_q <= key_mem[key_raddr];
  end

  // Weight memory.
  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[count_eff[IdxW-1:0]] <= in_i.weight;
    w_rd_q <= w_mem[w_raddr];
  end

  // Particle map memory.
  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rd_q <= map_mem[in_i.index];
  end

  // Unique position and weight sum memories.
  always_ff @(posedge clk_i) begin
    if (uni_we) begin
      upos_mem[uni_waddr] <= upos_wdata;
      usum_mem[uni_waddr] <= usum_wdata;
    end
    upos_rd_q <= upos_mem[in_i.index];
    usum_rd_q <= usum_mem[in_i.index];
  end

  // Field memory, read through the particle map.
  always_ff @(posedge clk_i) begin
    if (fld_we) fld_mem[fld_waddr] <= fld_wdata;
    fld_rd_q <= fld_mem[map_rd_q];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      distinct_q <= '0;
      reduced_q  <= 1'b0;
      overflow_q <= 1'b0;
      clr_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      u_q        <= '0;
      valid_q    <= 1'b0;
    end else begin
      count_q    <= count_d;
      distinct_q <= distinct_d;
      reduced_q  <= reduced_d;
      overflow_q <= overflow_d;
      clr_q      <= clr_d;
      i_q        <= i_d;
      j_q        <= j_d;
      u_q        <= u_d;
      valid_q    <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    cur_q  <= cur_d;
    upos_q <= upos_d;
    sum_q  <= sum_d;
    cmd_q  <= cmd_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = out_q;

  // The unique list never outgrows the batch.
  assert property (@(posedge clk_i) disable iff (!rst_ni) distinct_q <= count_q)
    else $error("distinct count exceeds particle count");

  // The batch never outgrows the memories.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("particle count exceeds capacity");

  // A result word only follows a response step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($past(op_i) == sur_pkg::OpResp1 || $past(op_i) == sur_pkg::OpResp2))
    else $error("result strobe without a response step");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the sort, merge and reduce-by-key block.
`timescale 1ns / 100ps

module testbench;
  import sur_pkg::*;

  // Codes outside the command set, which the block ignores.
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd5;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_word_t  in_i;
  logic      result_valid_o;
  out_word_t result_o;

  sort_unique_reduce_by_key dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_i          (in_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Clock with an 8 ns period.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Predicted block state.
  logic signed [PosW-1:0] pm_pos [MaxParticles];
  logic signed [WgtW-1:0] pm_wgt [MaxParticles];
  logic [IdxW-1:0]        pm_map [MaxParticles];
  logic signed [PosW-1:0] pm_upos [MaxParticles];
  logic signed [SumW-1:0] pm_usum [MaxParticles];
  logic signed [FldW-1:0] pm_fld [MaxParticles];
  int unsigned            pm_count;
  int unsigned            pm_distinct;
  bit                     pm_reduced;
  bit                     pm_overflow;

  out_word_t expected_words[$];
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned batches_done;
  int unsigned errors;
  bit          idle_on;

  // Sorts the batch by position and merges equal positions into unique entries.
  task automatic reduce_batch();
    int unsigned order [MaxParticles];
    int unsigned i;
    int unsigned j;
    int unsigned key;
    int unsigned u;
    for (i = 0; i < pm_count; i++) begin
      key = i;
      j = i;
      while (j > 0 && pm_pos[order[j-1]] > pm_pos[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    u = 0;
    pm_distinct = 0;
    for (i = 0; i < pm_count; i++) begin
      if (i == 0 || pm_pos[order[i]] > pm_upos[u]) begin
        if (i != 0) u++;
        pm_upos[u] = pm_pos[order[i]];
        pm_usum[u] = '0;
        pm_distinct = u + 1;
      end
      pm_map[order[i]] = IdxW'(u);
      pm_usum[u] = pm_usum[u] + SumW'(pm_wgt[order[i]]);
    end
    pm_reduced = 1'b1;
    batches_done++;
  endtask

  // Applies one accepted word to the predicted state and queues the result of a read.
  task automatic predict_word(input in_word_t w);
    out_word_t r;
    r = '0;
    case (w.command)
      CmdLoad: begin
        if (pm_reduced) begin
          pm_count = 0;
          pm_distinct = 0;
          pm_reduced = 1'b0;
          pm_overflow = 1'b0;
        end
        if (pm_count < MaxParticles) begin
          pm_pos[pm_count] = w.position;
          pm_wgt[pm_count] = w.weight;
          pm_count++;
        end else begin
          pm_overflow = 1'b1;
        end
        if (w.last) reduce_batch();
      end
      CmdLoadField: pm_fld[w.index] = w.field_in;
      CmdReadUnique, CmdReadMap, CmdReadField: begin
        if (!pm_reduced) begin
          r.status = StatNotReduced;
        end else if (w.command == CmdReadUnique) begin
          if (w.index < pm_distinct) begin
            r.unique_position = pm_upos[w.index];
            r.weight_sum = pm_usum[w.index];
          end else begin
            r.status = StatBadIndex;
          end
        end else if (w.index < pm_count) begin
          r.map_index = pm_map[w.index];
          if (w.command == CmdReadField) r.field_out = pm_fld[pm_map[w.index]];
        end else begin
          r.status = StatBadIndex;
        end
        if (r.status == StatOk && pm_overflow) r.status = StatOverflow;
        r.unique_count = CntW'(pm_distinct);
        expected_words.insert(expected_words.size(), r);
      end
      default: ;
    endcase
  endtask

  function automatic in_word_t mk_word(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                                       logic [WgtW-1:0] wgt, logic [FldW-1:0] fld,
                                       logic [IdxW-1:0] idx, logic lst);
    in_word_t w;
    w.command = cmd;
    w.position = pos;
    w.weight = wgt;
    w.field_in = fld;
    w.index = idx;
    w.last = lst;
    return w;
  endfunction

  // Sends one word, with an optional idle burst before it.
  task automatic send_word(input in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_i  <= w;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Holds off until every expected result is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (expected_words.size() != 0 || busy) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic send_read(logic [CmdW-1:0] cmd, int unsigned idx);
    send_word(mk_word(cmd, $urandom, $urandom, $urandom, IdxW'(idx),
                      1'($urandom_range(0, 1))));
  endtask

  // Compares each result word with the oldest prediction.
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", result_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (result_o.unique_position !== e.unique_position) begin
          $error("unique_position: expected %h, actual %h", e.unique_position,
                 result_o.unique_position);
          errors++;
        end
        if (result_o.weight_sum !== e.weight_sum) begin
          $error("weight_sum: expected %h, actual %h", e.weight_sum, result_o.weight_sum);
          errors++;
        end
        if (result_o.map_index !== e.map_index) begin
          $error("map_index: expected %0d, actual %0d", e.map_index, result_o.map_index);
          errors++;
        end
        if (result_o.field_out !== e.field_out) begin
          $error("field_out: expected %h, actual %h", e.field_out, result_o.field_out);
          errors++;
        end
        if (result_o.unique_count !== e.unique_count) begin
          $error("unique_count: expected %0d, actual %0d", e.unique_count,
                 result_o.unique_count);
          errors++;
        end
        if (result_o.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, result_o.status);
          errors++;
        end
      end
    end
  end

  // Reads before any batch exists, and ignored codes.
  task automatic test_unreduced_reads();
    send_read(CmdReadUnique, 0);
    send_read(CmdReadMap, 1023);
    send_read(CmdReadField, 5);
    send_word(mk_word(CmdSpareLo, '1, '1, '1, '1, 1'b1));
    send_word(mk_word(CmdSpareHi, '0, '0, '0, '0, 1'b0));
    drain();
  endtask

  // A small batch with extreme positions and weights, duplicates and bad indexes.
  task automatic test_directed_batch();
    send_word(mk_word(CmdLoad, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 1'b0));
    send_word(mk_word(CmdLoad, 32'h8000_0000, 32'h8000_0000, '0, '0, 1'b0));
    send_word(mk_word(CmdLoad, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 1'b0));
    send_word(mk_word(CmdReadUnique, '0, '0, '0, '0, 1'b0));
    send_word(mk_word(CmdLoad, 32'h8000_0000, 32'h8000_0000, '0, '0, 1'b0));
    send_word(mk_word(CmdLoad, 32'h0000_0000, 32'hFFFF_FFFF, '0, '0, 1'b1));
    send_word(mk_word(CmdLoadField, '0, '0, 32'h8000_0000, 10'd0, 1'b0));
    send_word(mk_word(CmdLoadField, '0, '0, 32'h7FFF_FFFF, 10'd2, 1'b0));
    send_word(mk_word(CmdLoadField, '0, '0, 32'hDEAD_BEEF, 10'd1023, 1'b0));
    for (int i = 0; i < 3; i++) send_read(CmdReadUnique, i);
    send_read(CmdReadUnique, 3);
    for (int i = 0; i < 5; i++) send_read(CmdReadField, i);
    send_read(CmdReadMap, 2);
    send_read(CmdReadMap, 5);
    send_read(CmdReadField, 1023);
    drain();
  endtask

  // A full batch in ascending order, then a dropped load that closes it.
  task automatic test_full_batch();
    for (int i = 0; i < MaxParticles; i++)
      send_word(mk_word(CmdLoad, PosW'(i / 2), $urandom, '0, '0, 1'b0));
    send_word(mk_word(CmdLoad, '0, 32'h1234_5678, '0, '0, 1'b1));
    send_read(CmdReadUnique, 511);
    send_read(CmdReadUnique, 512);
    send_read(CmdReadMap, 1023);
    send_read(CmdReadField, 1023);
    drain();
    // A new batch clears the overflow while the fields stay.
    send_word(mk_word(CmdLoad, 32'd3, 32'd7, '0, '0, 1'b0));
    send_read(CmdReadMap, 0);
    send_word(mk_word(CmdLoad, 32'd3, 32'd9, '0, '0, 1'b1));
    send_read(CmdReadUnique, 0);
    send_read(CmdReadField, 1);
    drain();
  endtask

  // Random batches, field loads and reads, with noise mixed in.
  task automatic test_random(int unsigned budget);
    int unsigned first;
    int unsigned size;
    int unsigned nreads;
    logic [PosW-1:0] pool [4];
    bit use_pool;
    first = words_sent;
    while (words_sent - first < budget) begin
      if (words_sent - first > budget * 85 / 100) idle_on = 1'b0;
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 24);
      use_pool = $urandom_range(0, 1);
      foreach (pool[k]) pool[k] = $urandom;
      for (int i = 0; i < size; i++) begin
        if ($urandom_range(0, 15) == 0) send_read($urandom_range(1, 4) == 3 ? CmdReadUnique
                                                  : CmdReadMap, $urandom_range(0, 1023));
        if ($urandom_range(0, 31) == 0)
          send_word(mk_word(CmdW'($urandom_range(CmdSpareLo, CmdSpareHi)), $urandom,
                            $urandom, $urandom, IdxW'($urandom),
                            1'($urandom_range(0, 1))));
        send_word(mk_word(CmdLoad, use_pool ? pool[$urandom_range(0, 3)] : $urandom,
                          $urandom, $urandom, IdxW'($urandom), i == size - 1));
      end
      for (int i = 0; i < $urandom_range(0, 8); i++)
        send_word(mk_word(CmdLoadField, $urandom, $urandom, $urandom,
                          IdxW'($urandom_range(0, 7) == 0 ? $urandom
                                : $urandom_range(0, pm_distinct)),
                          1'($urandom_range(0, 1))));
      nreads = $urandom_range(4, 20);
      for (int i = 0; i < nreads; i++)
        send_read($urandom_range(CmdReadUnique, CmdReadField) == CmdLoadField ? CmdReadField
                  : CmdW'($urandom_range(CmdReadUnique, CmdReadMap)),
                  $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
                  : $urandom_range(0, pm_count));
    end
    drain();
  endtask

  // Run timeout.
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    pm_count = 0;
    pm_distinct = 0;
    pm_reduced = 1'b0;
    pm_overflow = 1'b0;
    foreach (pm_fld[k]) pm_fld[k] = '0;
    words_sent = 0;
    results_seen = 0;
    batches_done = 0;
    errors = 0;
    idle_on = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_unreduced_reads();
    test_directed_batch();
    test_full_batch();
    test_random(440);
    $display("Sent %0d words over %0d reduced batches; checked %0d result words.",
             words_sent, batches_done, results_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
